@@ hdl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // Operation codes carried in the input request's tuser
    typedef enum logic [1:0]
    {
        OP_PUT   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;
    localparam logic [7:0]        ATTR_RESET = 8'h0F;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_ESC = 8'h1B;

endpackage

`default_nettype wire

@@ hdl/text_console_writer_core.sv @@
`default_nettype none

// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character code in the low byte) and a cursor.
// Input requests arrive on s_axis: tuser holds the operation (put character,
// move cursor, read cell, clear screen), tdata the operands. Every request
// yields exactly one result on m_axis: the cursor position after the request
// and, for a read, the cell contents (zero otherwise).
// The attribute for written cells is set through the APB port (register 0).
// Move and ignored characters go from idle straight to the done state, which
// loads the result register; put and read pass through their own state first.
// A newline on the last row, or a wrap past the last cell, scrolls the screen:
// the scroll state copies rows up, then the fill state blanks the last row;
// clear blanks every cell. Those walks are bound by the single write port of the
// screen RAM, which moves one cell per cycle; the row*COLUMNS+col address unit
// is shared by the write address, the scroll source and the cursor output.
// One request is in flight at a time; s_axis_tready is high only while idle.
// After reset the block blanks the screen RAM and holds s_axis_tready low
// meanwhile; APB writes are taken at any time.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the block only once a second result is
// ready to be handed over.
module text_console_writer_core
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Requests in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] char_code, [14:8] new_col, [19:15] new_row, [30:20] cell_index
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,

    // Results out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] cursor_pos, [26:11] cell_data
    output logic      [31:0] m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_SHIFT  = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] BOTTOM_BASE = AW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t            state_reg,   state_next;
    logic [AW-1:0]     ptr_reg,     ptr_next;
    logic [CW-1:0]     col_reg,     col_next;
    logic [RW-1:0]     row_reg,     row_next;
    logic [7:0]        attr_reg;
    logic [7:0]        code_reg,    code_next;
    logic [AW-1:0]     idx_reg,     idx_next;
    logic              hit_reg,     hit_next;
    logic              wr_en_reg,   wr_en_next;
    logic              wr_ram_reg,  wr_ram_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0] wr_data_reg, wr_data_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg,  m_data_next;

    // Request fields
    op_t               in_op;
    logic [7:0]        in_code;
    logic [6:0]        in_col;
    logic [4:0]        in_row;
    logic [10:0]       in_idx;

    logic              accept;
    logic              cfg_write;

    logic [RW-1:0]     au_row;
    logic [AW-1:0]     au_offset;
    logic [AW-1:0]     au_addr;

    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] out_cell;

    assign in_op   = op_t'(s_axis_tuser);
    assign in_code = s_axis_tdata[7:0];
    assign in_col  = s_axis_tdata[14:8];
    assign in_row  = s_axis_tdata[19:15];
    assign in_idx  = s_axis_tdata[30:20];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // APB: single attribute register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ATTR);
    assign prdata    = (paddr[2] == REG_ATTR) ? {24'd0, attr_reg} : 32'd0;

    // Shared address unit: scroll source is one row below the pointer,
    // otherwise the cursor cell.
    always_comb
    begin
        if (state_reg == ST_SCROLL)
        begin
            au_row    = RW'(1);
            au_offset = ptr_reg;
        end
        else
        begin
            au_row    = row_reg;
            au_offset = AW'(col_reg);
        end
    end

    tcw_addr_unit
    #(
        .COLUMNS (COLUMNS),
        .RW      (RW),
        .AW      (AW)
    )
    u_addr
    (
        .row    (au_row),
        .offset (au_offset),
        .addr   (au_addr)
    );

    assign ram_re    = (state_reg == ST_SCROLL) || (state_reg == ST_READ);
    assign ram_raddr = (state_reg == ST_SCROLL) ? au_addr : idx_reg;
    // Scroll copies land in the cycle after their read, straight from the read port
    assign ram_wdata = wr_ram_reg ? ram_rdata : wr_data_reg;

    tcw_screen_ram
    #(
        .DEPTH (CELLS),
        .AW    (AW)
    )
    u_ram
    (
        .clk   (clk),
        .we    (wr_en_reg),
        .waddr (wr_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_cell = hit_reg ? ram_rdata : '0;

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        code_next    = code_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        wr_en_next   = 1'b0;
        wr_ram_next  = 1'b0;
        wr_addr_next = wr_addr_reg;
        wr_data_next = wr_data_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // Blank one cell per cycle
                wr_en_next   = 1'b1;
                wr_addr_next = ptr_reg;
                wr_data_next = BLANK_CELL;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next  = 1'b0;
                    code_next = in_code;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (in_code == CHAR_NUL || in_code == CHAR_ESC)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_PUT;
                            end
                        end
                        OP_MOVE:
                        begin
                            // Saturate to the screen
                            col_next = (8'(in_col) < 8'(COLUMNS)) ? CW'(in_col) : LAST_COL;
                            row_next = (7'(in_row) < 7'(ROWS)) ? RW'(in_row) : LAST_ROW;
                            state_next = ST_DONE;
                        end
                        OP_READ:
                        begin
                            hit_next   = (14'(in_idx) < 14'(CELLS));
                            idx_next   = AW'(in_idx);
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (code_reg != CHAR_LF)
                begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = au_addr;
                    wr_data_next = {attr_reg, code_reg};
                end
                if (code_reg != CHAR_LF && col_reg != LAST_COL)
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // Newline or wrap: next row, scroll past the bottom
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        ptr_next   = '0;
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_DONE;
            end

            ST_SCROLL:
            begin
                // Read cell ptr+COLUMNS now, write it to ptr next cycle
                wr_en_next   = 1'b1;
                wr_ram_next  = 1'b1;
                wr_addr_next = ptr_reg;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == LAST_SHIFT)
                begin
                    ptr_next   = BOTTOM_BASE;
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = ptr_reg;
                wr_data_next = BLANK_CELL;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, out_cell, 11'(au_addr)};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            attr_reg    <= ATTR_RESET;
            hit_reg     <= 1'b0;
            wr_en_reg   <= 1'b0;
            wr_ram_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            hit_reg     <= hit_next;
            wr_en_reg   <= wr_en_next;
            wr_ram_reg  <= wr_ram_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write)
            begin
                attr_reg <= pwdata[7:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        idx_reg     <= idx_next;
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        m_data_reg  <= m_data_next;
    end

endmodule

`default_nettype wire

@@ hdl/tcw_screen_ram.sv @@
`default_nettype none

module tcw_screen_ram
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
)
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/tcw_addr_unit.sv @@
`default_nettype none

// Shared address unit: row * COLUMNS + offset
module tcw_addr_unit
#(
    parameter int COLUMNS = 80,
    parameter int RW      = 5,
    parameter int AW      = 11
)
(
    input  wire logic [RW-1:0] row,
    input  wire logic [AW-1:0] offset,
    output logic      [AW-1:0] addr
);

    logic [AW-1:0] prod;

    assign prod = AW'(row) * AW'(COLUMNS);
    assign addr = prod + offset;

endmodule

`default_nettype wire
